// ----- rtl/core/wtcq_pkg.sv -----
`timescale 1ns / 1ps
// package for the weighted three-class queue server
// types, codes, widths and reset values shared by all core files
package wtcq_pkg;

    localparam int ID_W  = 32;
    localparam int AGE_W = 7;
    localparam int WGT_W = 3;
    localparam int CLS_W = 2;
    localparam int NUM_CLASSES = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 7;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int S_TDATA_W = ((ID_W + AGE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ID_W + AGE_W + CLS_W + 2 + 7) / 8) * 8;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    localparam logic [CLS_W-1:0] CLS_FIRST  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SECOND = 2'd1;
    localparam logic [CLS_W-1:0] CLS_THIRD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_AGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_AGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_WGT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WGT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_WGT  = 3'd4;

    localparam logic [AGE_W-1:0] UPPER_AGE_RST  = 7'd55;
    localparam logic [AGE_W-1:0] LOWER_AGE_RST  = 7'd40;
    localparam logic [WGT_W-1:0] FIRST_WGT_RST  = 3'd3;
    localparam logic [WGT_W-1:0] SECOND_WGT_RST = 3'd1;
    localparam logic [WGT_W-1:0] THIRD_WGT_RST  = 3'd1;

    typedef logic [CLS_W-1:0] class_t;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic   served;
        logic   dropped;
        class_t cls;
    } sched_res_t;

endpackage

// ----- rtl/core/wtcq_mem.sv -----
`timescale 1ns / 1ps
// entry storage for all three queues, one write and one registered read port
// depends on wtcq_pkg for the entry type
module wtcq_mem
    import wtcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int ADDR_W = PTR_W + CLS_W
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    localparam int MEM_DEPTH = NUM_CLASSES * (1 << PTR_W);

    entry_t mem [MEM_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/wtcq_sched.sv -----
`timescale 1ns / 1ps
// queue pointers, fill counts and weighted rotation state
// depends on wtcq_pkg; drives the ports of wtcq_mem
module wtcq_sched
    import wtcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int ADDR_W = PTR_W + CLS_W
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             op,
    input  logic [AGE_W-1:0]                 age,
    input  logic [AGE_W-1:0]                 upper_age,
    input  logic [AGE_W-1:0]                 lower_age,
    input  logic [NUM_CLASSES-1:0][WGT_W-1:0] weights,
    output logic                             wr_en,
    output logic [ADDR_W-1:0]                wr_addr,
    output logic                             rd_en,
    output logic [ADDR_W-1:0]                rd_addr,
    output sched_res_t                       res,
    output logic                             all_empty
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0] rptr_reg [NUM_CLASSES];
    logic [PTR_W-1:0] wptr_reg [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_reg  [NUM_CLASSES];
    class_t           cur_reg, cur_next;
    logic [WGT_W-1:0] turn_reg, turn_next;
    sched_res_t       res_reg, res_next;

    logic [NUM_CLASSES-1:0] nonempty;
    logic [NUM_CLASSES-1:0] full;
    class_t                 enq_cls;
    logic                   enq_do;
    logic [PTR_W-1:0]       enq_ptr;
    logic [PTR_W-1:0]       srv_ptr;
    class_t                 c_v;
    logic [WGT_W-1:0]       t_v;
    logic                   hit;
    logic                   wrap;

    always_comb
    begin
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            nonempty[k] = (cnt_reg[k] != '0);
            full[k]     = (cnt_reg[k] >= CNT_FULL);
        end
    end

    assign all_empty = ~|nonempty;

    // class selection by age thresholds
    always_comb
    begin
        if (age > upper_age)
        begin
            enq_cls = CLS_FIRST;
        end
        else if (age > lower_age)
        begin
            enq_cls = CLS_SECOND;
        end
        else
        begin
            enq_cls = CLS_THIRD;
        end
    end

    assign enq_do  = accept && (op == OP_ENQUEUE) && !full[enq_cls];
    assign enq_ptr = wptr_reg[enq_cls];

    // weighted rotation, at most one pass over the three classes
    always_comb
    begin
        c_v  = (cur_reg > CLS_THIRD) ? CLS_FIRST : cur_reg;
        t_v  = turn_reg;
        hit  = 1'b0;
        wrap = 1'b0;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            if (!hit && !wrap)
            begin
                if ((t_v < weights[c_v]) && nonempty[c_v])
                begin
                    hit = 1'b1;
                end
                else
                begin
                    t_v = '0;
                    if (c_v == CLS_THIRD)
                    begin
                        c_v  = CLS_FIRST;
                        wrap = 1'b1;
                    end
                    else
                    begin
                        c_v = c_v + 2'd1;
                    end
                end
            end
        end
    end

    assign srv_ptr = rptr_reg[c_v];

    assign wr_en   = enq_do;
    assign wr_addr = {enq_cls, enq_ptr};
    assign rd_en   = accept && (op == OP_SERVE) && hit;
    assign rd_addr = {c_v, srv_ptr};

    always_comb
    begin
        cur_next  = cur_reg;
        turn_next = turn_reg;
        res_next  = res_reg;
        if (accept)
        begin
            res_next = '{served: 1'b0, dropped: 1'b0, cls: CLS_FIRST};
            if (op == OP_ENQUEUE)
            begin
                res_next.dropped = full[enq_cls];
            end
            else
            begin
                cur_next = c_v;
                if (hit)
                begin
                    turn_next       = t_v + 3'd1;
                    res_next.served = 1'b1;
                    res_next.cls    = c_v;
                end
                else
                begin
                    turn_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                rptr_reg[k] <= '0;
                wptr_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
            cur_reg  <= CLS_FIRST;
            turn_reg <= '0;
            res_reg  <= '{served: 1'b0, dropped: 1'b0, cls: CLS_FIRST};
        end
        else
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                if (wr_en && (enq_cls == CLS_W'(k)))
                begin
                    wptr_reg[k] <= (wptr_reg[k] == PTR_LAST) ? '0 : wptr_reg[k] + PTR_W'(1);
                    cnt_reg[k]  <= cnt_reg[k] + CNT_W'(1);
                end
                if (rd_en && (c_v == CLS_W'(k)))
                begin
                    rptr_reg[k] <= (rptr_reg[k] == PTR_LAST) ? '0 : rptr_reg[k] + PTR_W'(1);
                    cnt_reg[k]  <= cnt_reg[k] - CNT_W'(1);
                end
            end
            cur_reg  <= cur_next;
            turn_reg <= turn_next;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

    a_no_serve_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_SERVE) && all_empty |=> !res.served)
        else $error("serve granted with all queues empty");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CNT_FULL) && (cnt_reg[1] <= CNT_FULL) && (cnt_reg[2] <= CNT_FULL))
        else $error("fill count above queue depth");

    a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !res.dropped)
        else $error("entry written and reported dropped");

endmodule

// ----- rtl/core/weighted_three_class_queue_server_top.sv -----
`timescale 1ns / 1ps
// top level of the weighted three-class queue server
// depends on wtcq_pkg, wtcq_sched and wtcq_mem
//
//  channel  handshake            payload
//  s_*      s_tvalid / s_tready  tuser: operation; tdata: person_id, age
//  m_*      m_tvalid / m_tready  tuser: served; tdata: id, age, class, dropped, all_empty
//  cfg_*    cfg_valid / cfg_ready cfg_index, cfg_data
//
// a request first updates pointer state and accesses the entry memory, then its registered
// read data moves into the output register
// a new request is taken once the previous result sits in the output register
// reset clears pointers, counts and rotation; entry memory needs no clearing
// a stalled m_tready holds the result and keeps s_tready low after one more request
// cfg_ready is always high; writes beyond the register list are ignored
module weighted_three_class_queue_server_top
    import wtcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // person_id, age, zero pad
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata, // served_id, served_age, served_class, dropped, all_empty
    output logic                  m_tuser,   // served
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W = PTR_W + CLS_W;
    localparam int OUT_BITS = ID_W + AGE_W + CLS_W + 2;

    typedef enum logic {ST_IDLE, ST_RESP} state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_served_reg;
    logic [OUT_BITS-1:0] out_data_reg;

    logic [AGE_W-1:0] upper_age_reg;
    logic [AGE_W-1:0] lower_age_reg;
    logic [NUM_CLASSES-1:0][WGT_W-1:0] weights_reg;

    logic              accept;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            wr_data;
    entry_t            rd_data;
    sched_res_t        res;
    logic              all_empty;
    logic              out_free;
    entry_t            srv_entry;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign wr_data.id  = s_tdata[ID_W-1:0];
    assign wr_data.age = s_tdata[ID_W +: AGE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_age_reg  <= UPPER_AGE_RST;
            lower_age_reg  <= LOWER_AGE_RST;
            weights_reg[0] <= FIRST_WGT_RST;
            weights_reg[1] <= SECOND_WGT_RST;
            weights_reg[2] <= THIRD_WGT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_UPPER_AGE:  upper_age_reg  <= cfg_data[AGE_W-1:0];
                REG_LOWER_AGE:  lower_age_reg  <= cfg_data[AGE_W-1:0];
                REG_FIRST_WGT:  weights_reg[0] <= cfg_data[WGT_W-1:0];
                REG_SECOND_WGT: weights_reg[1] <= cfg_data[WGT_W-1:0];
                REG_THIRD_WGT:  weights_reg[2] <= cfg_data[WGT_W-1:0];
                default:        ;
            endcase
        end
    end

    wtcq_sched #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (s_tuser),
        .age       (s_tdata[ID_W +: AGE_W]),
        .upper_age (upper_age_reg),
        .lower_age (lower_age_reg),
        .weights   (weights_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .res       (res),
        .all_empty (all_empty)
    );

    wtcq_mem #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign srv_entry = res.served ? rd_data : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            out_served_reg <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (accept)
                    begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_served_reg <= res.served;
                        out_data_reg   <= {all_empty, res.dropped, res.cls,
                                           srv_entry.age, srv_entry.id};
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_served_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_BITS){1'b0}}, out_data_reg};

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request taken while another is in flight");

    a_served_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[ID_W + AGE_W + CLS_W])
        else $error("result both served and dropped");

    a_served_not_empty_before: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP) && res.served |-> rd_en == 1'b0)
        else $error("memory read issued while a result is pending");

endmodule

// ----- tb/sv/weighted_three_class_queue_server_top_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for weighted_three_class_queue_server_top
// depends on wtcq_pkg and the rtl core; predicts every result with its own rotation tracker
module weighted_three_class_queue_server_top_tb;
    import wtcq_pkg::*;

    typedef struct packed {
        logic             served;
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
        class_t           cls;
        logic             dropped;
        logic             all_empty;
    } result_t;

    class queue_server_scoreboard;
        logic [AGE_W-1:0] upper_age;
        logic [AGE_W-1:0] lower_age;
        logic [WGT_W-1:0] weight [NUM_CLASSES];
        entry_t           slot [NUM_CLASSES][QUEUE_DEPTH_DEF];
        int unsigned      rd_ptr [NUM_CLASSES];
        int unsigned      wr_ptr [NUM_CLASSES];
        int unsigned      fill [NUM_CLASSES];
        class_t           cur_cls;
        logic [WGT_W-1:0] turn;
        result_t          pending_results [$];
        int               errors;

        function new();
            upper_age = UPPER_AGE_RST;
            lower_age = LOWER_AGE_RST;
            weight[0] = FIRST_WGT_RST;
            weight[1] = SECOND_WGT_RST;
            weight[2] = THIRD_WGT_RST;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                rd_ptr[k] = 0;
                wr_ptr[k] = 0;
                fill[k] = 0;
            end
            cur_cls = CLS_FIRST;
            turn = '0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_UPPER_AGE:  upper_age = val[AGE_W-1:0];
                REG_LOWER_AGE:  lower_age = val[AGE_W-1:0];
                REG_FIRST_WGT:  weight[0] = val[WGT_W-1:0];
                REG_SECOND_WGT: weight[1] = val[WGT_W-1:0];
                REG_THIRD_WGT:  weight[2] = val[WGT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(logic op, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
            result_t r;
            class_t  c;
            bit      done;
            r = '0;
            if (op == OP_ENQUEUE)
            begin
                if (age > upper_age)
                    c = CLS_FIRST;
                else if (age > lower_age)
                    c = CLS_SECOND;
                else
                    c = CLS_THIRD;
                if (fill[c] >= QUEUE_DEPTH_DEF)
                    r.dropped = 1'b1;
                else
                begin
                    slot[c][wr_ptr[c]] = '{age: age, id: id};
                    wr_ptr[c] = (wr_ptr[c] + 1) % QUEUE_DEPTH_DEF;
                    fill[c]++;
                end
            end
            else
            begin
                done = 0;
                while (!done)
                begin
                    if (turn < weight[cur_cls] && fill[cur_cls] != 0)
                    begin
                        r.served = 1'b1;
                        r.id = slot[cur_cls][rd_ptr[cur_cls]].id;
                        r.age = slot[cur_cls][rd_ptr[cur_cls]].age;
                        r.cls = cur_cls;
                        rd_ptr[cur_cls] = (rd_ptr[cur_cls] + 1) % QUEUE_DEPTH_DEF;
                        fill[cur_cls]--;
                        turn = turn + WGT_W'(1);
                        done = 1;
                    end
                    else
                    begin
                        turn = '0;
                        // wrapping past the third class ends the serve empty-handed
                        if (cur_cls == CLS_THIRD)
                        begin
                            cur_cls = CLS_FIRST;
                            done = 1;
                        end
                        else
                            cur_cls = cur_cls + CLS_W'(1);
                    end
                end
            end
            r.all_empty = (fill[0] == 0 && fill[1] == 0 && fill[2] == 0);
            pending_results.push_back(r);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                report("result with no request waiting");
                return;
            end
            exp = pending_results.pop_front();
            if (got.served !== exp.served)
                report($sformatf("served %0b, wanted %0b", got.served, exp.served));
            if (got.id !== exp.id)
                report($sformatf("served_id %h, wanted %h", got.id, exp.id));
            if (got.age !== exp.age)
                report($sformatf("served_age %0d, wanted %0d", got.age, exp.age));
            if (got.cls !== exp.cls)
                report($sformatf("served_class %0d, wanted %0d", got.cls, exp.cls));
            if (got.dropped !== exp.dropped)
                report($sformatf("dropped %0b, wanted %0b", got.dropped, exp.dropped));
            if (got.all_empty !== exp.all_empty)
                report($sformatf("all_empty %0b, wanted %0b", got.all_empty, exp.all_empty));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // person_id, age, zero pad
    logic                  s_tuser;    // operation
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;    // served_id, served_age, served_class, dropped, all_empty
    logic                  m_tuser;    // served
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    queue_server_scoreboard sb;
    bit calm;

    weighted_three_class_queue_server_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver with random stall bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.served = m_tuser;
            got.id = m_tdata[ID_W-1:0];
            got.age = m_tdata[ID_W +: AGE_W];
            got.cls = m_tdata[ID_W + AGE_W +: CLS_W];
            got.dropped = m_tdata[ID_W + AGE_W + CLS_W];
            got.all_empty = m_tdata[ID_W + AGE_W + CLS_W + 1];
            sb.check_result(got);
        end
    end

    task send_request(logic op, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[ID_W-1:0] = id;
        d[ID_W +: AGE_W] = age;
        @(negedge clk);
        s_tdata <= d;
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, id, age);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    endtask

    task wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task write_all(int upper, int lower, int w0, int w1, int w2);
        wait_drained();
        write_reg(REG_UPPER_AGE, upper[CFG_DATA_W-1:0]);
        write_reg(REG_LOWER_AGE, lower[CFG_DATA_W-1:0]);
        write_reg(REG_FIRST_WGT, w0[CFG_DATA_W-1:0]);
        write_reg(REG_SECOND_WGT, w1[CFG_DATA_W-1:0]);
        write_reg(REG_THIRD_WGT, w2[CFG_DATA_W-1:0]);
    endtask

    // ages cluster around the thresholds half the time
    function automatic logic [AGE_W-1:0] pick_age();
        int a;
        case ($urandom_range(0, 3))
            0: a = int'(sb.upper_age) + int'($urandom_range(0, 2)) - 1;
            1: a = int'(sb.lower_age) + int'($urandom_range(0, 2)) - 1;
            default: a = int'($urandom_range(0, 127));
        endcase
        if (a < 0)
            a = 0;
        if (a > 127)
            a = 127;
        return a[AGE_W-1:0];
    endfunction

    task run_phase(int n, int enq_pct, bit hold_mid);
        for (int k = 0; k < n; k++)
        begin
            if (hold_mid && k == n / 2)
                wait_drained();
            if ($urandom_range(0, 99) < enq_pct)
                send_request(OP_ENQUEUE, $urandom, pick_age());
            else
                send_request(OP_SERVE, $urandom, AGE_W'($urandom_range(0, 127)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ENQUEUE;
        cfg_valid = 1'b0;
        cfg_index = REG_UPPER_AGE;
        cfg_data = '0;
        calm = 0;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty serve, threshold edges, extreme ids, third class overflow
        send_request(OP_SERVE, 32'h0, 7'd0);
        send_request(OP_ENQUEUE, 32'h0000_0000, 7'd0);
        send_request(OP_ENQUEUE, 32'hFFFF_FFFF, 7'd127);
        send_request(OP_ENQUEUE, 32'hA5A5_A5A5, 7'd55);
        send_request(OP_ENQUEUE, 32'h5A5A_5A5A, 7'd56);
        send_request(OP_ENQUEUE, 32'h0000_0001, 7'd40);
        send_request(OP_ENQUEUE, 32'h8000_0000, 7'd41);
        repeat (14) send_request(OP_ENQUEUE, $urandom, AGE_W'($urandom_range(0, 40)));
        send_request(OP_ENQUEUE, 32'hDEAD_0000, 7'd0);
        repeat (3) send_request(OP_SERVE, 32'hFFFF_FFFF, 7'd127);

        write_all(127, 0, 7, 7, 7);
        run_phase(230, 60, 0);
        // crossed thresholds
        write_all(0, 127, 1, 1, 1);
        run_phase(230, 50, 0);
        // first class never served
        write_all(63, 20, 0, 2, 5);
        run_phase(230, 55, 1);
        write_all(30, 90, 7, 0, 0);
        run_phase(230, 50, 0);
        write_all($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(1, 7),
                  $urandom_range(1, 7), $urandom_range(1, 7));
        run_phase(230, 70, 0);
        write_all($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 7),
                  $urandom_range(0, 7), $urandom_range(0, 7));
        run_phase(230, 35, 0);
        write_all(55, 40, 3, 1, 1);
        run_phase(230, 50, 0);
        write_all($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(1, 7),
                  $urandom_range(1, 7), $urandom_range(1, 7));
        calm = 1;
        run_phase(230, 50, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
